>>> rtl/tpdq_pkg.sv
// Shared widths, constants, beat types and the xorshift step for the TPDF quantizer.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package tpdq_pkg;

   localparam int SAMPLE_W = 40;
   localparam int PCM_W    = 24;
   localparam int BYTE_W   = 8;
   localparam int STATE_W  = 32;
   localparam int DITHER_W = 9;
   localparam int X_W      = 32;
   localparam int SUM_W    = SAMPLE_W + 1;
   localparam int PROD_W   = 56;
   localparam int FRAC_W   = 31;
   localparam int FLOOR_W  = PROD_W - FRAC_W;

   localparam logic [STATE_W-1:0] SEED_RESET = 32'h4153_4D42;

   // Clamp window of the dithered sample, Q31 units.
   localparam logic signed [X_W-1:0] X_LO = 32'sh8000_0000;
   localparam logic signed [X_W-1:0] X_HI = 32'sd2147483392;

   localparam logic [FRAC_W-1:0] HALF_LSB = 31'h4000_0000;

   localparam logic signed [PCM_W-1:0] PCM_MIN = 24'sh80_0000;
   localparam logic signed [PCM_W-1:0] PCM_MAX = 24'sh7F_FFFF;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [DITHER_W-1:0] dither;
   } dither_beat_type;

   typedef struct packed {
      logic signed [PROD_W-1:0] product;
   } product_beat_type;

   // One xorshift step, shifts 13, 17, 5.
   function automatic logic [STATE_W-1:0] xorshift32(input logic [STATE_W-1:0] s);
      logic [STATE_W-1:0] a;
      logic [STATE_W-1:0] b;
      a = s ^ (s << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

endpackage
`default_nettype wire

>>> rtl/tpdq_if.sv
// Request and response channel interfaces of the TPDF quantizer.
// Depends on tpdq_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none
interface tpdq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tpdq_pkg::SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface tpdq_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [tpdq_pkg::PCM_W-1:0]  pcm_value;
   logic        [tpdq_pkg::BYTE_W-1:0] low_byte;
   logic        [tpdq_pkg::BYTE_W-1:0] mid_byte;
   logic        [tpdq_pkg::BYTE_W-1:0] high_byte;

   modport source (output valid, output pcm_value, output low_byte, output mid_byte,
                   output high_byte, input ready);
   modport sink   (input valid, input pcm_value, input low_byte, input mid_byte,
                   input high_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/tpdq_dither_stage.sv
// Input stage: xorshift noise state, TPDF dither draw and the sample register.
// Depends on tpdq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpdq_dither_stage (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [tpdq_pkg::STATE_W-1:0]         csr_wdata,
   input  wire logic                                 in_valid,
   output      logic                                 in_ready,
   input  wire logic signed [tpdq_pkg::SAMPLE_W-1:0] in_sample,
   output      logic                                 out_valid,
   input  wire logic                                 out_ready,
   output      tpdq_pkg::dither_beat_type            out_beat
);

   logic [tpdq_pkg::STATE_W-1:0]         state_ff, state_in;
   logic [tpdq_pkg::STATE_W-1:0]         draw_a, draw_b;
   logic signed [tpdq_pkg::PCM_W:0]      diff;
   logic signed [tpdq_pkg::DITHER_W-1:0] dither;
   logic                                 valid_ff;
   tpdq_pkg::dither_beat_type            beat_ff, beat_in;
   logic                                 accept;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      draw_a = tpdq_pkg::xorshift32(state_ff);
      draw_b = tpdq_pkg::xorshift32(draw_a);
      diff   = $signed({1'b0, draw_a[tpdq_pkg::PCM_W-1:0]})
             - $signed({1'b0, draw_b[tpdq_pkg::PCM_W-1:0]});
      // truncate toward zero: bump a negative quotient that dropped fraction bits
      dither = diff[tpdq_pkg::PCM_W:16]
             + $signed({{(tpdq_pkg::DITHER_W-1){1'b0}}, diff[tpdq_pkg::PCM_W] && (|diff[15:0])});
      beat_in.sample = in_sample;
      beat_in.dither = dither;
   end

   always_comb begin
      state_in = state_ff;
      if (csr_we) begin
         state_in = csr_wdata;
      end else if (accept) begin
         state_in = draw_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpdq_pkg::SEED_RESET;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         beat_ff <= beat_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tpdq_scale_stage.sv
// Middle stage: add dither, clamp to full scale, scale by 8388607 (shift and subtract).
// Depends on tpdq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpdq_scale_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire tpdq_pkg::dither_beat_type in_beat,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      tpdq_pkg::product_beat_type out_beat
);

   logic signed [tpdq_pkg::SUM_W-1:0]  sum;
   logic signed [tpdq_pkg::X_W-1:0]    x;
   logic signed [tpdq_pkg::PROD_W-1:0] x_ext;
   logic                               valid_ff;
   tpdq_pkg::product_beat_type         beat_ff, beat_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      sum = $signed({in_beat.sample[tpdq_pkg::SAMPLE_W-1], in_beat.sample})
          + $signed({{(tpdq_pkg::SUM_W-tpdq_pkg::DITHER_W){in_beat.dither[tpdq_pkg::DITHER_W-1]}},
                     in_beat.dither});
      if (sum < $signed({{(tpdq_pkg::SUM_W-tpdq_pkg::X_W){1'b1}}, tpdq_pkg::X_LO})) begin
         x = tpdq_pkg::X_LO;
      end else if (sum > $signed({{(tpdq_pkg::SUM_W-tpdq_pkg::X_W){1'b0}}, tpdq_pkg::X_HI})) begin
         x = tpdq_pkg::X_HI;
      end else begin
         x = sum[tpdq_pkg::X_W-1:0];
      end
      x_ext = $signed({{(tpdq_pkg::PROD_W-tpdq_pkg::X_W){x[tpdq_pkg::X_W-1]}}, x});
      beat_in.product = (x_ext <<< 23) - x_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= beat_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tpdq_round_stage.sv
// Output stage: round half to even from Q31, clamp to 24 bits, hold the result beat.
// Depends on tpdq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tpdq_round_stage (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   output      logic                              in_ready,
   input  wire tpdq_pkg::product_beat_type        in_beat,
   output      logic                              out_valid,
   input  wire logic                              out_ready,
   output      logic signed [tpdq_pkg::PCM_W-1:0] out_code
);

   logic signed [tpdq_pkg::FLOOR_W-1:0] fl;
   logic        [tpdq_pkg::FRAC_W-1:0]  rem;
   logic                                up;
   logic signed [tpdq_pkg::FLOOR_W:0]   rounded;
   logic signed [tpdq_pkg::PCM_W-1:0]   code_in, code_ff;
   logic                                valid_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_code  = code_ff;

   always_comb begin
      fl      = in_beat.product[tpdq_pkg::PROD_W-1:tpdq_pkg::FRAC_W];
      rem     = in_beat.product[tpdq_pkg::FRAC_W-1:0];
      up      = (rem > tpdq_pkg::HALF_LSB) || ((rem == tpdq_pkg::HALF_LSB) && fl[0]);
      rounded = $signed({fl[tpdq_pkg::FLOOR_W-1], fl})
              + $signed({{tpdq_pkg::FLOOR_W{1'b0}}, up});
      if (rounded < $signed({{(tpdq_pkg::FLOOR_W+1-tpdq_pkg::PCM_W){1'b1}}, tpdq_pkg::PCM_MIN}))
      begin
         code_in = tpdq_pkg::PCM_MIN;
      end else if (rounded >
                   $signed({{(tpdq_pkg::FLOOR_W+1-tpdq_pkg::PCM_W){1'b0}}, tpdq_pkg::PCM_MAX}))
      begin
         code_in = tpdq_pkg::PCM_MAX;
      end else begin
         code_in = rounded[tpdq_pkg::PCM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         code_ff <= code_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/tpdf_dithered_pcm24_quantizer_core.sv
// Top level of the TPDF-dithered 24-bit PCM quantizer: three-stage pipeline.
// Depends on tpdq_pkg, tpdq_if and the tpdq_*_stage modules.
//
//   channel  | role   | payload                                  | beat accepted at
//   ---------+--------+------------------------------------------+-----------------------
//   req_bus  | sink   | sample (Q31, 40 bits signed)             | valid && ready
//   rsp_bus  | source | pcm_value, low_byte, mid_byte, high_byte | valid && ready
//   csr_*    | write  | csr_wdata = dither_seed (32 bits)        | csr_we
//
// One beat per cycle sustained while the response side is ready; a request beat reaches
// its response through the registers after dither draw, scaling and rounding.
// Each stage holds its beat while the next one is full and stalled, so a waiting
// response blocks nothing until all three stages are full.
// Reset (synchronous, active high) empties the pipe and loads the noise state with
// the seed reset value; a csr write loads the noise state at once.
`timescale 1ns / 1ps
`default_nettype none
module tpdf_dithered_pcm24_quantizer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [tpdq_pkg::STATE_W-1:0]     csr_wdata,
   tpdq_req_if.sink                              req_bus,
   tpdq_rsp_if.source                            rsp_bus
);

   logic                              d_valid, d_ready;
   tpdq_pkg::dither_beat_type         d_beat;
   logic                              p_valid, p_ready;
   tpdq_pkg::product_beat_type        p_beat;
   logic signed [tpdq_pkg::PCM_W-1:0] code;

   // Draw two noise values per accepted beat and register sample with its dither.
   tpdq_dither_stage u_dither (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_sample (req_bus.sample),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .out_beat  (d_beat)
   );

   // Add dither, clamp, scale by 8388607.
   tpdq_scale_stage u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .in_beat   (d_beat),
      .out_valid (p_valid),
      .out_ready (p_ready),
      .out_beat  (p_beat)
   );

   // Round half to even, clamp to 24 bits; this register is the response register.
   tpdq_round_stage u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_beat   (p_beat),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_code  (code)
   );

   // Split the code into little-endian bytes.
   assign rsp_bus.pcm_value = code;
   assign rsp_bus.low_byte  = code[7:0];
   assign rsp_bus.mid_byte  = code[15:8];
   assign rsp_bus.high_byte = code[23:16];

endmodule
`default_nettype wire

>>> rtl/tpdq_checker.sv
// Port-level checks of the TPDF quantizer core, attached by bind.
// Depends on tpdq_pkg and the top level tpdf_dithered_pcm24_quantizer_core.
`timescale 1ns / 1ps
`default_nettype none
module tpdq_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [tpdq_pkg::PCM_W-1:0]        rsp_pcm_value,
   input wire logic [tpdq_pkg::BYTE_W-1:0]       rsp_low_byte,
   input wire logic [tpdq_pkg::BYTE_W-1:0]       rsp_mid_byte,
   input wire logic [tpdq_pkg::BYTE_W-1:0]       rsp_high_byte
);

   // Pipe is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pcm_value))
      else $error("stalled response beat changed or dropped");

   // Bytes agree with the code.
   a_bytes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_low_byte == rsp_pcm_value[7:0]
                 && rsp_mid_byte == rsp_pcm_value[15:8]
                 && rsp_high_byte == rsp_pcm_value[23:16])
      else $error("response bytes do not match the code");

   // With the sink ready, an accepted request passes the dither, scale and round registers and shows up.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("accepted request did not reach the response register");

endmodule

bind tpdf_dithered_pcm24_quantizer_core tpdq_checker u_tpdq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_pcm_value (rsp_bus.pcm_value),
   .rsp_low_byte  (rsp_bus.low_byte),
   .rsp_mid_byte  (rsp_bus.mid_byte),
   .rsp_high_byte (rsp_bus.high_byte)
);
`default_nettype wire
